// ----- hw/rtl/spd_pkg.sv -----
`timescale 1ns / 1ps

package spd_pkg;

  localparam int LINE_CAPACITY_DEF = 64;
  localparam int JOB_DEPTH_DEF     = 2;
  localparam int EVT_DEPTH_DEF     = 4;

  localparam int LINE_BYTES   = 15;
  localparam int BTN_LINE_LEN = 4;
  localparam int NUM_AXES     = 6;
  localparam int NUM_BUTTONS  = 10;

  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_D  = 8'h64;
  localparam logic [7:0] CHAR_K  = 8'h6B;

  localparam logic [1:0] EV_AXIS   = 2'd0;
  localparam logic [1:0] EV_BUTTON = 2'd1;
  localparam logic [1:0] EV_FLUSH  = 2'd2;

  localparam logic [7:0] PAR_FIRST [16] = '{
    8'hE0, 8'hA0, 8'hA0, 8'h60, 8'hA0, 8'h60, 8'h60, 8'hA0,
    8'h90, 8'h50, 8'h50, 8'h90, 8'hD0, 8'h90, 8'h90, 8'h50
  };

  localparam logic [7:0] PAR_SECOND [64] = '{
    8'h80, 8'h40, 8'h40, 8'h80, 8'h40, 8'h80, 8'h80, 8'h40,
    8'h40, 8'h80, 8'h80, 8'h40, 8'h80, 8'h40, 8'h40, 8'h80,
    8'h40, 8'h80, 8'h80, 8'h40, 8'h80, 8'h40, 8'h40, 8'h80,
    8'h80, 8'h40, 8'h40, 8'h80, 8'hC0, 8'h80, 8'h80, 8'h40,
    8'hC0, 8'h80, 8'h80, 8'h40, 8'h80, 8'h40, 8'h40, 8'h80,
    8'h80, 8'h40, 8'h40, 8'h80, 8'h40, 8'h80, 8'h80, 8'h40,
    8'h80, 8'h40, 8'h40, 8'h80, 8'h40, 8'h80, 8'h80, 8'h40,
    8'h40, 8'h80, 8'h80, 8'h40, 8'h80, 8'h40, 8'h00, 8'h80
  };

  typedef logic [LINE_BYTES-1:0][7:0] line_t;

  typedef struct packed {
    logic  is_axis;
    line_t bytes;
  } job_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         index;
    logic signed [10:0] value;
    logic               last;
  } evt_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SCAN,
    B_CHECK,
    B_AXIS,
    B_FLUSH,
    B_BTN
  } b_state_t;

endpackage

// ----- hw/rtl/spd_fifo.sv -----
`timescale 1ns / 1ps

module spd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_r, wr_nxt, rd_r, rd_nxt;
  logic [AW:0]      cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == (AW + 1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_r] <= wdata;
    end
  end

endmodule

// ----- hw/rtl/spd_front.sv -----
`timescale 1ns / 1ps

module spd_front import spd_pkg::*; #(
  parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic [7:0] in_rx_byte,
  input  logic       job_full,
  output logic       job_push,
  output job_t       job_data
);

  line_t      line_r;
  logic [7:0] len_r, len_nxt, len_inc;
  logic       accept, is_term, is_d, is_k;

  assign accept  = in_push && !job_full;
  assign is_term = (in_rx_byte == CHAR_CR) || (in_rx_byte == CHAR_LF);
  assign is_d    = (len_r == 8'(LINE_BYTES)) && (line_r[0] == CHAR_D);
  assign is_k    = (len_r == 8'(BTN_LINE_LEN)) && (line_r[0] == CHAR_K);
  assign len_inc = len_r + 8'd1;

  assign job_push         = accept && is_term && (is_d || is_k);
  assign job_data.is_axis = is_d;
  assign job_data.bytes   = line_r;

  always_comb begin
    len_nxt = len_r;
    if (accept) begin
      if (is_term) begin
        len_nxt = '0;
      end else begin
        len_nxt = (len_inc >= 8'(LINE_CAPACITY)) ? 8'd0 : len_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      line_r <= '0;
    end else begin
      len_r <= len_nxt;
      if (accept && !is_term && (len_r < 8'(LINE_BYTES))) begin
        line_r[len_r[3:0]] <= in_rx_byte;
      end
    end
  end

endmodule

// ----- hw/rtl/spd_back.sv -----
`timescale 1ns / 1ps

module spd_back import spd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic job_valid,
  input  job_t job_in,
  output logic job_pop,
  input  logic ev_full,
  output logic ev_push,
  output evt_t ev_data
);

  b_state_t           state_r, state_nxt;
  line_t              job_r, job_nxt;
  logic [3:0]         cnt_r, cnt_nxt;
  logic [5:0]         chk_r, chk_nxt;
  logic               par_r, par_nxt;
  logic               any_r, any_nxt;
  logic signed [10:0] vals_r [NUM_AXES];
  logic signed [10:0] vals_nxt [NUM_AXES];
  logic signed [10:0] prev_r [NUM_AXES];
  logic signed [10:0] prev_nxt [NUM_AXES];
  logic [2:0][7:0]    btn_r, btn_nxt;
  logic [9:0]         rem_r, rem_nxt;

  logic [2:0]         ax;
  logic [7:0]         b1, b2;
  logic [9:0]         raw;
  logic signed [10:0] v;
  logic               pair_ok, ax_changed, chk_ok, emit_want, step;
  logic [9:0]         btn_cur, rem_clr;
  logic [3:0]         bpos;
  logic [10:0]        btn_val;

  function automatic logic [9:0] btn_bits(input logic [2:0][7:0] b);
    btn_bits = {b[2][2:1], b[1][3:0], b[0][3:0]};
  endfunction

  assign ax      = cnt_r[2:0];
  assign b1      = job_r[{ax, 1'b1}];
  assign b2      = job_r[4'({ax, 1'b0}) + 4'd2];
  assign raw     = {b1[3:0], b2[5:0]};
  assign v       = (raw > 10'd512) ? {1'b1, raw} : {1'b0, raw};
  assign pair_ok = (b1[7:4] == PAR_FIRST[b1[3:0]][7:4]) &&
                   (b2[7:6] == PAR_SECOND[b2[5:0]][7:6]);

  // The offset term equals v >>> 6 in every case, and the final wrap by 64
  // leaves the low six bits alone, so the checksum is kept modulo 64.
  assign chk_ok     = par_r && (chk_r == job_r[LINE_BYTES-1][5:0]);
  assign ax_changed = (vals_r[ax] != prev_r[ax]);

  assign btn_cur = btn_bits(btn_r);
  assign rem_clr = rem_r & ~(10'd1 << cnt_r);
  always_comb begin
    case (cnt_r)
      4'd8:    bpos = 4'd1;
      4'd9:    bpos = 4'd2;
      default: bpos = {2'b00, cnt_r[1:0]};
    endcase
  end
  assign btn_val = btn_cur[cnt_r] ? (11'd1 << bpos) : 11'd0;

  always_comb begin
    case (state_r)
      B_AXIS:  emit_want = ax_changed;
      B_FLUSH: emit_want = 1'b1;
      B_BTN:   emit_want = rem_r[cnt_r];
      default: emit_want = 1'b0;
    endcase
  end
  assign step = !emit_want || !ev_full;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (job_valid) begin
          state_nxt = job_in.is_axis ? B_SCAN : B_BTN;
        end
      end
      B_SCAN: begin
        if (cnt_r == 4'(NUM_AXES - 1)) begin
          state_nxt = B_CHECK;
        end
      end
      B_CHECK: begin
        state_nxt = chk_ok ? B_AXIS : B_IDLE;
      end
      B_AXIS: begin
        if (step && (cnt_r == 4'(NUM_AXES - 1))) begin
          state_nxt = (any_r || ax_changed) ? B_FLUSH : B_IDLE;
        end
      end
      B_FLUSH: begin
        if (step) begin
          state_nxt = B_IDLE;
        end
      end
      B_BTN: begin
        if (step && (cnt_r == 4'(NUM_BUTTONS - 1))) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    job_nxt  = job_r;
    cnt_nxt  = cnt_r;
    chk_nxt  = chk_r;
    par_nxt  = par_r;
    any_nxt  = any_r;
    vals_nxt = vals_r;
    prev_nxt = prev_r;
    btn_nxt  = btn_r;
    rem_nxt  = rem_r;
    job_pop  = 1'b0;
    ev_push  = 1'b0;
    ev_data  = '0;
    case (state_r)
      B_IDLE: begin
        if (job_valid) begin
          job_pop = 1'b1;
          job_nxt = job_in.bytes;
          cnt_nxt = '0;
          chk_nxt = '0;
          par_nxt = 1'b1;
          if (!job_in.is_axis) begin
            btn_nxt = job_in.bytes[3:1];
            rem_nxt = btn_bits(job_in.bytes[3:1]) ^ btn_bits(btn_r);
          end
        end
      end
      B_SCAN: begin
        vals_nxt[ax] = v;
        chk_nxt      = chk_r + v[5:0] + {v[10], v[10:6]};
        par_nxt      = par_r && pair_ok;
        cnt_nxt      = cnt_r + 4'd1;
      end
      B_CHECK: begin
        cnt_nxt = '0;
        any_nxt = 1'b0;
      end
      B_AXIS: begin
        if (ax_changed && !ev_full) begin
          ev_push       = 1'b1;
          ev_data.kind  = EV_AXIS;
          ev_data.index = cnt_r;
          ev_data.value = vals_r[ax];
          prev_nxt[ax]  = vals_r[ax];
          any_nxt       = 1'b1;
        end
        if (step) begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      B_FLUSH: begin
        if (!ev_full) begin
          ev_push      = 1'b1;
          ev_data.kind = EV_FLUSH;
          ev_data.last = 1'b1;
        end
      end
      B_BTN: begin
        if (rem_r[cnt_r] && !ev_full) begin
          ev_push       = 1'b1;
          ev_data.kind  = EV_BUTTON;
          ev_data.index = cnt_r;
          ev_data.value = btn_val;
          ev_data.last  = (rem_clr == '0);
          rem_nxt       = rem_clr;
        end
        if (step) begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      cnt_r   <= '0;
      any_r   <= 1'b0;
      btn_r   <= '0;
      rem_r   <= '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        prev_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      any_r   <= any_nxt;
      btn_r   <= btn_nxt;
      rem_r   <= rem_nxt;
      prev_r  <= prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    chk_r  <= chk_nxt;
    par_r  <= par_nxt;
    vals_r <= vals_nxt;
  end

endmodule

// ----- hw/rtl/sixaxis_serial_packet_decoder_top.sv -----
`timescale 1ns / 1ps

// Channel   Ports                                   Beat accepted when
// input     in_push, in_full, in_rx_byte            in_push && !in_full
// result    out_pop, out_empty, out_event_*,        out_pop && !out_empty
//           out_last_event
//
// A byte that does not end a line is taken and gives no result.
// A line end hands the line to the event engine through a job queue; a 'd'
// line is scanned and checked and, if it passes, takes one cycle per axis
// and a flush event if any axis changed; a 'k' line one cycle per button bit.
// Reset is synchronous and active low and leaves all history at zero.
// A full event queue stalls the engine; a full job queue raises in_full.

module sixaxis_serial_packet_decoder_top import spd_pkg::*; #(
  parameter int LINE_CAPACITY = LINE_CAPACITY_DEF,
  parameter int JOB_DEPTH     = JOB_DEPTH_DEF,
  parameter int EVT_DEPTH     = EVT_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_rx_byte,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [1:0]         out_event_kind,
  output logic [3:0]         out_event_index,
  output logic signed [10:0] out_event_value,
  output logic               out_last_event
);

  logic                    job_push, job_full, job_empty, job_pop;
  job_t                    job_wr, job_rd;
  logic [$bits(job_t)-1:0] job_rdata;
  logic                    ev_push, ev_full;
  evt_t                    ev_wr, ev_rd;
  logic [$bits(evt_t)-1:0] ev_rdata;

  spd_front #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_rx_byte(in_rx_byte),
    .job_full  (job_full),
    .job_push  (job_push),
    .job_data  (job_wr)
  );

  spd_fifo #(
    .WIDTH($bits(job_t)),
    .DEPTH(JOB_DEPTH)
  ) u_jobq (
    .clk  (clk),
    .rst_n(rst_n),
    .push (job_push),
    .wdata(job_wr),
    .full (job_full),
    .pop  (job_pop),
    .rdata(job_rdata),
    .empty(job_empty)
  );

  assign job_rd  = job_t'(job_rdata);
  assign in_full = job_full;

  spd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_valid(!job_empty),
    .job_in   (job_rd),
    .job_pop  (job_pop),
    .ev_full  (ev_full),
    .ev_push  (ev_push),
    .ev_data  (ev_wr)
  );

  spd_fifo #(
    .WIDTH($bits(evt_t)),
    .DEPTH(EVT_DEPTH)
  ) u_evq (
    .clk  (clk),
    .rst_n(rst_n),
    .push (ev_push),
    .wdata(ev_wr),
    .full (ev_full),
    .pop  (out_pop),
    .rdata(ev_rdata),
    .empty(out_empty)
  );

  assign ev_rd           = evt_t'(ev_rdata);
  assign out_event_kind  = ev_rd.kind;
  assign out_event_index = ev_rd.index;
  assign out_event_value = ev_rd.value;
  assign out_last_event  = ev_rd.last;

  a_flush_last : assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_event_kind == EV_FLUSH) |-> out_last_event)
    else $error("flush event without last mark");

  a_axis_not_last : assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_event_kind == EV_AXIS) |-> !out_last_event)
    else $error("axis event marked last");

  a_data_byte_no_job : assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full && in_rx_byte != CHAR_CR && in_rx_byte != CHAR_LF)
      |-> !job_push)
    else $error("line job from a data byte");

  a_job_pop_valid : assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> !job_empty)
    else $error("job taken from empty queue");

endmodule
